/* rtl/scm_pkg.sv */
// Shared types and constants for the serial command keyword matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package scm_pkg;

	localparam int SLOTS       = 8;
	localparam int KEY_CHARS   = 8;
	localparam int KEY_W       = 8 * KEY_CHARS;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int LINE_LENGTH = 32;
	localparam int POS_W       = 6;
	localparam int LEN_W       = 4;

	localparam logic [7:0] CR_BYTE    = 8'd13;
	localparam logic [7:0] SPACE_BYTE = 8'd32;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	localparam logic [POS_W-1:0] LINE_FULL    = POS_W'(LINE_LENGTH);
	localparam logic [LEN_W-1:0] KEY_LEN      = LEN_W'(KEY_CHARS);
	localparam logic [LEN_W-1:0] KEY_LEN_OVER = LEN_W'(KEY_CHARS + 1);

	typedef enum logic [1:0] {
		PHASE_BEFORE = 2'd0,
		PHASE_IN     = 2'd1,
		PHASE_AFTER  = 2'd2
	} phase_t;

	typedef logic [SLOTS-1:0][KEY_W-1:0] kw_array_t;

	typedef struct packed {
		logic              matched;
		logic [SLOT_W-1:0] slot_index;
	} scm_result_t;

	// Character of a keyword at a word position; zero beyond the last slot byte.
	function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] kw,
			input logic [LEN_W-1:0] pos);
		logic [7:0] b;
		b = 8'd0;
		if (pos < KEY_LEN)
			b = kw[8 * pos[2:0] +: 8];
		return b;
	endfunction

endpackage

`default_nettype wire

/* rtl/scm_keyword_bank.sv */
// Keyword slot registers, loaded through the plain configuration write port.
// Depends on scm_pkg.
`default_nettype none

module scm_keyword_bank
	import scm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [SLOT_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]  cfg_data,
	output kw_array_t              keywords
);

	kw_array_t kw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q <= '0;
		end else if (cfg_wr_en) begin
			kw_q[cfg_index] <= cfg_data;
		end
	end

	assign keywords = kw_q;

endmodule

`default_nettype wire

/* rtl/scm_line_matcher.sv */
// Line state and per-character keyword comparison; one byte per step.
// Depends on scm_pkg.
`default_nettype none

module scm_line_matcher
	import scm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	input  wire kw_array_t  keywords,
	output logic            res_valid,
	output scm_result_t     result
);

	logic [POS_W-1:0] pos_q;
	phase_t           phase_q;
	logic [LEN_W-1:0] len_q;
	logic [SLOTS-1:0] cand_q;

	logic             is_cr;
	logic             is_print;
	logic             restart;
	logic [POS_W-1:0] pos_eff;
	phase_t           phase_eff;
	logic [LEN_W-1:0] len_eff;
	logic [SLOTS-1:0] cand_eff;
	logic [SLOTS-1:0] keep;
	logic [SLOTS-1:0] hits;
	logic [POS_W-1:0] pos_d;
	phase_t           phase_d;
	logic [LEN_W-1:0] len_d;
	logic [SLOTS-1:0] cand_d;

	assign is_cr    = (byte_in == CR_BYTE);
	assign is_print = (byte_in >= PRINT_LO) && (byte_in <= PRINT_HI);
	assign restart  = is_print && (pos_q >= LINE_FULL);

	// a printable byte on a full line starts a fresh line first
	always_comb begin
		pos_eff   = restart ? '0 : pos_q;
		phase_eff = restart ? PHASE_BEFORE : phase_q;
		len_eff   = restart ? '0 : len_q;
		cand_eff  = restart ? '1 : cand_q;
	end

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			keep[k] = (key_byte(keywords[k], len_eff) == byte_in);
			hits[k] = cand_q[k] && (len_q <= KEY_LEN) &&
				((len_q == KEY_LEN) || (key_byte(keywords[k], len_q) == 8'd0));
		end
	end

	always_comb begin
		result.matched    = |hits;
		result.slot_index = '0;
		for (int k = SLOTS - 1; k >= 0; k--) begin
			if (hits[k])
				result.slot_index = SLOT_W'(k);
		end
		res_valid = is_cr && (phase_q != PHASE_BEFORE);
	end

	always_comb begin
		pos_d   = pos_q;
		phase_d = phase_q;
		len_d   = len_q;
		cand_d  = cand_q;
		if (is_cr) begin
			pos_d   = '0;
			phase_d = PHASE_BEFORE;
			len_d   = '0;
			cand_d  = '1;
		end else if (is_print) begin
			pos_d   = pos_eff + POS_W'(1);
			phase_d = phase_eff;
			len_d   = len_eff;
			cand_d  = cand_eff;
			if (byte_in == SPACE_BYTE) begin
				if (phase_eff == PHASE_IN)
					phase_d = PHASE_AFTER;
			end else if (phase_eff != PHASE_AFTER) begin
				phase_d = PHASE_IN;
				if (len_eff < KEY_LEN)
					cand_d = cand_eff & keep;
				else
					cand_d = '0;
				if (len_eff < KEY_LEN_OVER)
					len_d = len_eff + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PHASE_BEFORE;
			len_q   <= '0;
			cand_q  <= '1;
		end else if (step) begin
			pos_q   <= pos_d;
			phase_q <= phase_d;
			len_q   <= len_d;
			cand_q  <= cand_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/serial_command_keyword_matcher.sv */
// Serial command keyword matcher: input word register, line matcher, result register.
// Depends on scm_pkg, scm_keyword_bank and scm_line_matcher.
//
// Usage:
//   Received bytes enter on in_valid/in_ready/rx_byte, one word per cycle if ready.
//   Printable bytes build a line; the first space-delimited word is compared
//   against eight keyword slots as it arrives. A carriage return ends the
//   line and, if the line holds a word, one result word leaves on
//   out_valid/out_ready with matched and slot_index (lowest matching slot).
//   Empty lines and non-printable bytes give no result.
//   Keywords are loaded through cfg_wr_en/cfg_index/cfg_data while idle.
// Timing:
//   out_valid rises once the accepted carriage return has passed from the input
//   register into the result register; the result can leave at the next edge.
//   Throughput is one byte per cycle while no carriage return is held; each byte
//   is compared against all eight slots in parallel in the line matcher.
// Reset and stall:
//   arst_n clears the keywords, the line state and both valid flags.
//   While a result waits, the input register keeps accepting bytes; only a
//   second carriage return is held until the pending result is taken.
`default_nettype none

module serial_command_keyword_matcher
	import scm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        rx_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   matched,
	output logic [SLOT_W-1:0]      slot_index,
	input  wire logic              cfg_wr_en,
	input  wire logic [SLOT_W-1:0] cfg_index,
	input  wire logic [KEY_W-1:0]  cfg_data
);

	kw_array_t   keywords;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	scm_result_t out_q;
	logic        res_valid;
	scm_result_t result;
	logic        fire;

	scm_keyword_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keywords  (keywords)
	);

	// hold a carriage return only while the result register is still full
	assign fire     = valid_s1 && ((byte_s1 != CR_BYTE) || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	scm_line_matcher u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire),
		.byte_in   (byte_s1),
		.keywords  (keywords),
		.res_valid (res_valid),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid)
			out_q <= result;
	end

	assign out_valid  = out_valid_q;
	assign matched    = out_q.matched;
	assign slot_index = out_q.slot_index;

endmodule

`default_nettype wire

/* verif/tb_serial_command_keyword_matcher.sv */
// Testbench for serial_command_keyword_matcher: directed lines, then random keyword sets and lines.
// The line predictor or a pinned row checks every result word. Needs scm_pkg and the matcher RTL.
`default_nettype none

module tb_serial_command_keyword_matcher;
	import scm_pkg::*;

	typedef enum logic [SLOT_W-1:0] {
		KW_SLOT0, KW_SLOT1, KW_SLOT2, KW_SLOT3, KW_SLOT4, KW_SLOT5, KW_SLOT6, KW_SLOT7
	} kw_reg_t;

	typedef struct {
		logic [7:0]  rx;
		bit          pinned;
		scm_result_t verdict;
	} directed_row_t;

	localparam int DIRECTED_ROWS   = 25;
	localparam int FIRST_KEYED_ROW = 2;
	localparam int RANDOM_BYTES    = 1150;
	localparam int PHASE_BYTES     = 100;
	localparam int IDLE_PCT        = 16;
	localparam int CALM_FIRST      = 3;
	localparam int CALM_LAST       = 4;
	localparam int SETTLE_CYCLES   = 4;
	localparam int STALL_LIMIT     = 2000;
	localparam scm_result_t NO_VERDICT = '0;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic              matched;
	logic [SLOT_W-1:0] slot_index;
	logic              cfg_wr_en;
	logic [SLOT_W-1:0] cfg_index;
	logic [KEY_W-1:0]  cfg_data;

	serial_command_keyword_matcher u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.matched    (matched),
		.slot_index (slot_index),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Line predictor state and keyword copy
	kw_array_t        keyword_model;
	int               line_pos;
	phase_t           word_phase;
	int               word_len;
	logic [SLOTS-1:0] candidates;

	scm_result_t   expected_verdicts[$];
	directed_row_t directed_rows[DIRECTED_ROWS];
	bit            pin_row;
	scm_result_t   pin_val;
	int            idle_pct;
	int            bytes_taken;
	int            stall_cycles;
	int            failures;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] kw_char(input int slot, input int pos);
		if (pos >= KEY_CHARS)
			return 8'h00;
		return keyword_model[slot][8 * pos +: 8];
	endfunction

	function automatic void clear_line();
		line_pos   = 0;
		word_phase = PHASE_BEFORE;
		word_len   = 0;
		candidates = '1;
	endfunction

	// Advance the line state by one byte; return 1 when the byte closes a line with a word.
	function automatic bit match_byte(input logic [7:0] c, output scm_result_t verdict);
		logic [SLOTS-1:0] hits;
		logic [SLOTS-1:0] keep;
		bit               ends;
		verdict = NO_VERDICT;
		if (c == CR_BYTE) begin
			if (word_phase == PHASE_BEFORE) begin
				clear_line();
				return 1'b0;
			end
			for (int k = 0; k < SLOTS; k++) begin
				ends = (word_len <= KEY_CHARS) &&
					(word_len == KEY_CHARS || kw_char(k, word_len) == 8'h00);
				hits[k] = candidates[k] && ends;
			end
			for (int k = SLOTS - 1; k >= 0; k--)
				if (hits[k])
					verdict.slot_index = SLOT_W'(k);
			verdict.matched = |hits;
			clear_line();
			return 1'b1;
		end
		if (c < PRINT_LO || c > PRINT_HI)
			return 1'b0;
		if (line_pos >= LINE_LENGTH)
			clear_line();
		line_pos++;
		if (c == SPACE_BYTE) begin
			if (word_phase == PHASE_IN)
				word_phase = PHASE_AFTER;
			return 1'b0;
		end
		if (word_phase == PHASE_BEFORE)
			word_phase = PHASE_IN;
		if (word_phase == PHASE_IN) begin
			if (word_len < KEY_CHARS) begin
				for (int k = 0; k < SLOTS; k++)
					keep[k] = (kw_char(k, word_len) == c);
				candidates &= keep;
			end else begin
				candidates = '0;
			end
			if (word_len < KEY_CHARS + 1)
				word_len++;
		end
		return 1'b0;
	endfunction

	// Small alphabet most of the time so that keywords share prefixes and lines hit them.
	function automatic logic [7:0] word_char();
		if ($urandom_range(3) == 0)
			return 8'($urandom_range(8'h21, PRINT_HI));
		return 8'("a" + $urandom_range(3));
	endfunction

	function automatic logic [KEY_W-1:0] pack_keyword(input string s);
		logic [KEY_W-1:0] kw;
		kw = '0;
		for (int i = 0; i < s.len() && i < KEY_CHARS; i++)
			kw[8 * i +: 8] = s[i];
		return kw;
	endfunction

	function automatic logic [KEY_W-1:0] random_keyword();
		logic [KEY_W-1:0] kw;
		int               len;
		kw = '0;
		case ($urandom_range(19))
			0: kw = '0;
			1: kw = '1;
			2: kw = {$urandom, $urandom};
			3: for (int i = 0; i < KEY_CHARS; i++) kw[8 * i +: 8] = PRINT_HI;
			4: kw = {$urandom, $urandom} & ~KEY_W'(8'hFF);
			5: kw = pack_keyword("a b");
			default: begin
				len = ($urandom_range(3) == 0) ? KEY_CHARS : $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					kw[8 * i +: 8] = word_char();
			end
		endcase
		return kw;
	endfunction

	// Sample both channels at the rising edge; predict on input, check on output.
	always @(posedge clk) begin
		scm_result_t verdict;
		scm_result_t seen;
		bit          fresh;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (in_valid && in_ready) begin
			bytes_taken++;
			fresh = match_byte(rx_byte, verdict);
			if (pin_row)
				expected_verdicts.push_back(pin_val);
			else if (fresh)
				expected_verdicts.push_back(verdict);
		end
		if (out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result word: matched %0d slot_index %0d", matched, slot_index);
				failures++;
			end else begin
				seen = expected_verdicts.pop_front();
				if (matched !== seen.matched) begin
					$error("matched: expected %0d, got %0d", seen.matched, matched);
					failures++;
				end
				if (slot_index !== seen.slot_index) begin
					$error("slot_index: expected %0d, got %0d", seen.slot_index, slot_index);
					failures++;
				end
			end
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("serial_command_keyword_matcher test failed");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready = ($urandom_range(99) >= idle_pct);

	task automatic send_byte(input logic [7:0] b, input bit pinned, input scm_result_t pin);
		int n;
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		n        = bytes_taken;
		in_valid = 1'b1;
		rx_byte  = b;
		pin_row  = pinned;
		pin_val  = pin;
		do @(negedge clk); while (bytes_taken == n);
	endtask

	// Drain all results, then let the pipeline empty before touching keywords.
	task automatic settle();
		in_valid = 1'b0;
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_keyword(input kw_reg_t idx, input logic [KEY_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		keyword_model[idx] = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Build one line, mostly around a configured keyword; leave it open when finish is 0.
	task automatic send_line(input bit finish);
		logic [7:0] chars[$];
		int         k;
		int         len;
		int         mode;
		k    = $urandom_range(SLOTS - 1);
		mode = $urandom_range(9);
		repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
			chars.push_back(SPACE_BYTE);
		if (mode < 6) begin
			for (int p = 0; p < KEY_CHARS && kw_char(k, p) != 8'h00; p++)
				chars.push_back(kw_char(k, p));
			case ($urandom_range(5))
				0: if (chars.size() > 0) void'(chars.pop_back());
				1: chars.push_back(word_char());
				2: if (chars.size() > 0) chars[$urandom_range(chars.size() - 1)] = word_char();
				default: ;
			endcase
		end else if (mode < 8) begin
			repeat ($urandom_range(1, 12)) chars.push_back(word_char());
		end
		if ($urandom_range(2) == 0) begin
			chars.push_back(SPACE_BYTE);
			repeat ($urandom_range(1, 5)) chars.push_back(word_char());
		end
		// Run some lines up to and past the line limit.
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: len = LINE_LENGTH - 1;
				1: len = LINE_LENGTH;
				2: len = LINE_LENGTH + 1;
				default: len = $urandom_range(LINE_LENGTH + 2, 2 * LINE_LENGTH + 6);
			endcase
			while (chars.size() < len)
				chars.push_back($urandom_range(4) == 0 ? SPACE_BYTE : word_char());
		end
		if (finish)
			chars.push_back(CR_BYTE);
		foreach (chars[i]) begin
			if ($urandom_range(11) == 0)
				send_byte(8'($urandom_range(255)), 1'b0, NO_VERDICT);
			send_byte(chars[i], 1'b0, NO_VERDICT);
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = 8'h00;
		out_ready    = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = KW_SLOT0;
		cfg_data     = '0;
		pin_row      = 1'b0;
		pin_val      = NO_VERDICT;
		idle_pct     = IDLE_PCT;
		bytes_taken  = 0;
		stall_cycles = 0;
		failures     = 0;
		keyword_model = '0;
		clear_line();

		directed_rows = '{
			'{"x", 1'b0, NO_VERDICT}, '{CR_BYTE, 1'b1, '{1'b0, 3'd0}},
			'{CR_BYTE, 1'b0, NO_VERDICT},
			'{SPACE_BYTE, 1'b0, NO_VERDICT}, '{CR_BYTE, 1'b0, NO_VERDICT},
			'{SPACE_BYTE, 1'b0, NO_VERDICT}, '{"g", 1'b0, NO_VERDICT}, '{"o", 1'b0, NO_VERDICT},
			'{SPACE_BYTE, 1'b0, NO_VERDICT}, '{"z", 1'b0, NO_VERDICT},
			'{CR_BYTE, 1'b0, NO_VERDICT},
			'{"A", 1'b0, NO_VERDICT}, '{"B", 1'b0, NO_VERDICT}, '{"C", 1'b0, NO_VERDICT},
			'{"D", 1'b0, NO_VERDICT}, '{"E", 1'b0, NO_VERDICT}, '{"F", 1'b0, NO_VERDICT},
			'{"G", 1'b0, NO_VERDICT}, '{"H", 1'b0, NO_VERDICT},
			'{CR_BYTE, 1'b1, '{1'b1, 3'd1}},
			'{PRINT_HI, 1'b0, NO_VERDICT}, '{8'h00, 1'b0, NO_VERDICT},
			'{8'hFF, 1'b0, NO_VERDICT}, '{8'h7F, 1'b0, NO_VERDICT},
			'{CR_BYTE, 1'b1, '{1'b1, 3'd6}}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (i == FIRST_KEYED_ROW) begin
				settle();
				load_keyword(KW_SLOT0, pack_keyword("go"));
				load_keyword(KW_SLOT1, pack_keyword("ABCDEFGH"));
				load_keyword(KW_SLOT2, pack_keyword("go"));
				load_keyword(KW_SLOT3, '1);
				// empty keyword: zero low byte with text behind it
				load_keyword(KW_SLOT4, KEY_W'(24'h626100));
				load_keyword(KW_SLOT5, pack_keyword("a b"));
				load_keyword(KW_SLOT6, pack_keyword("~"));
				load_keyword(KW_SLOT7, pack_keyword(" "));
			end
			send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].verdict);
		end

		for (int ph = 0; bytes_taken < DIRECTED_ROWS + RANDOM_BYTES; ph++) begin
			int target;
			settle();
			idle_pct = (ph >= CALM_FIRST && ph <= CALM_LAST) ? 0 : IDLE_PCT;
			for (int k = 0; k < SLOTS; k++)
				if (ph == 0 || $urandom_range(2) != 0)
					load_keyword(kw_reg_t'(k), random_keyword());
			if ($urandom_range(3) == 0)
				load_keyword(kw_reg_t'($urandom_range(SLOTS - 1)),
					keyword_model[$urandom_range(SLOTS - 1)]);
			target = bytes_taken + PHASE_BYTES;
			while (bytes_taken < target)
				send_line(1'b1);
			// Leave a line open so the next keyword set lands mid-line.
			if ($urandom_range(2) == 0)
				send_line(1'b0);
		end
		settle();

		if (failures == 0)
			$display("serial_command_keyword_matcher test passed");
		else
			$display("serial_command_keyword_matcher test failed");
		$finish;
	end

endmodule

`default_nettype wire
